FILE: rtl/salc_pkg.sv
// ---------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache counter.
// ---------------------------------------------------------------------------
package salc_pkg;

    // Field widths of the access and result items.
    localparam int ADDR_W = 64;
    localparam int FUNC_W = 2;
    localparam int TAG_W  = 64;
    localparam int CNT_W  = 32;

    // One stored line: valid bit above the tag.
    localparam int ENT_W = TAG_W + 1;

    // Result packing: hits, miss, eviction, then the three running totals.
    localparam int RES_W = 2 + 1 + 1 + 3 * CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_W       = 3;
    localparam int WAYS_W     = 4;
    localparam int BB_W       = 6;
    localparam int SPLIT_W    = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // Access kind that counts one extra hit.
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rd;   // request accepted: latch address fields, read the set
        logic upd;  // write back the reordered set and load the result
    } t_cmd;

endpackage

FILE: rtl/set_assoc_lru_cache_counter.sv
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_counter
// Set-associative LRU cache model that counts hits, misses and evictions.
// ---------------------------------------------------------------------------
// Each request on the slave stream is one memory access: tuser carries the
// access kind, tdata the 64-bit byte address. Each access gives exactly one
// request on the master stream with this access's hit, miss and eviction
// counts and the three saturating running totals.
// The configuration channel writes set_bits (index 0), ways (index 1) and
// block_bits (index 2); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. An accepted access
// reads its set's row from the set memory; the lookup state compares the
// tags of the ways in use in parallel and, once the result register is
// free, writes the reordered row back and registers the result. No new
// access is accepted meanwhile, bound by the single row read and write.
// Reset clears the totals, the configuration and the per-set written flags,
// so every line reads invalid; the memory needs no clearing pass.
// While the receiver stalls the result holds; one further access can be
// accepted and waits in the lookup stage until the result register frees.
// ---------------------------------------------------------------------------
module set_assoc_lru_cache_counter
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Access stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [ADDR_W-1:0]     i_s_tdata,   // [63:0] address
    input  logic [FUNC_W-1:0]     i_s_tuser,   // [1:0] func
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [1:0] access_hits, [2] access_miss, [3] access_eviction,
    // [35:4] total_hits, [67:36] total_misses, [99:68] total_evictions,
    // [103:100] zero
    output logic [OUT_W-1:0]      o_m_tdata,
    // Configuration channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // Sequencing and handshakes.
    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    // Lookup, replacement and counting.
    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_s_tuser),
        .i_addr      (i_s_tdata),
        .o_result    (o_m_tdata)
    );

endmodule

FILE: rtl/salc_ram.sv
// ---------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/salc_dp.sv
// ---------------------------------------------------------------------------
// salc_dp
// Datapath: configuration registers, address split, set memory, tag lookup,
// LRU reorder of the set, and the saturating running totals.
// ---------------------------------------------------------------------------
module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [ADDR_W-1:0]     i_addr,
    output logic [OUT_W-1:0]      o_result
);

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * ENT_W;

    // Configuration registers.
    logic [SB_W-1:0]   r_set_bits;
    logic [WAYS_W-1:0] r_ways;
    logic [BB_W-1:0]   r_block_bits;

    // Fields of the request in flight.
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;
    logic              r_modify;
    logic              r_init;

    // One flag per set: the set has been written since reset.
    logic [NUM_SETS-1:0] r_row_init;

    // Result and totals.
    logic [1:0]        r_acc_hits;
    logic              r_acc_miss;
    logic              r_acc_evict;
    logic [CNT_W-1:0]  r_tot_hits;
    logic [CNT_W-1:0]  r_tot_misses;
    logic [CNT_W-1:0]  r_tot_evicts;

    logic [SB_W-1:0]    w_sb;
    logic [NW_W-1:0]    w_nw;
    logic [SPLIT_W-1:0] w_split;
    logic [ADDR_W-1:0]  w_shifted;
    logic [SET_W-1:0]   w_set_mask;
    logic [SET_W-1:0]   w_set;
    logic [TAG_W-1:0]   w_tag;

    logic [ROW_W-1:0]   w_rdata;
    logic [ROW_W-1:0]   w_row;
    logic [ROW_W-1:0]   w_new;
    logic               w_found;
    logic [WAY_W-1:0]   w_hit_idx;
    logic [WAY_W-1:0]   w_lim;
    logic               w_all_valid;
    logic               w_evict;
    logic [1:0]         w_hits;
    logic [CNT_W:0]     w_hit_sum;
    logic [CNT_W:0]     w_miss_sum;
    logic [CNT_W:0]     w_evict_sum;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways       <= WAYS_W'(1);
            r_block_bits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SB_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BB_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the set bit count and the way count to what the storage holds; zero ways count as one.
    always_comb begin
        w_sb = (32'(r_set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : r_set_bits;
        if (r_ways == '0) begin
            w_nw = NW_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            w_nw = NW_W'(MAX_WAYS);
        end else begin
            w_nw = NW_W'(r_ways);
        end
        w_split = SPLIT_W'(w_sb) + SPLIT_W'(r_block_bits);
    end

    // Split the incoming address into set index and tag.
    always_comb begin
        w_shifted = i_addr >> r_block_bits;
        for (int k = 0; k < SET_W; k++) begin
            w_set_mask[k] = (k < 32'(w_sb));
        end
        w_set = w_shifted[SET_W-1:0] & w_set_mask;
        w_tag = (w_split >= SPLIT_W'(ADDR_W)) ? '0 : (i_addr >> w_split);
    end

    // Latch the request fields while the set is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_set    <= w_set;
            r_tag    <= w_tag;
            r_modify <= (i_func == FUNC_MODIFY);
            r_init   <= r_row_init[w_set];
        end
    end

    // Set memory: one row holds every way of a set, most recent way lowest.
    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_set),
        .i_wdata (w_new),
        .i_re    (i_cmd.rd),
        .i_raddr (w_set),
        .o_rdata (w_rdata)
    );

    // A set never written reads as all lines invalid with zero tags.
    assign w_row = r_init ? w_rdata : '0;

    // Parallel tag compare over the ways in use; the lowest match wins.
    always_comb begin
        w_found     = 1'b0;
        w_hit_idx   = '0;
        w_all_valid = 1'b1;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if ((i < 32'(w_nw)) && w_row[i*ENT_W+TAG_W]
                    && (w_row[i*ENT_W +: TAG_W] == r_tag)) begin
                w_found   = 1'b1;
                w_hit_idx = WAY_W'(i);
            end
            if ((i < 32'(w_nw)) && !w_row[i*ENT_W+TAG_W]) begin
                w_all_valid = 1'b0;
            end
        end
        w_evict = !w_found && w_all_valid;
        w_hits  = 2'(w_found) + 2'(r_modify);
    end

    // Reorder: ways up to the hit (or the last way in use) move down one,
    // and the accessed tag enters as most recent.
    always_comb begin
        w_lim = w_found ? w_hit_idx : WAY_W'(w_nw - NW_W'(1));
        w_new = w_row;
        w_new[0 +: ENT_W] = {1'b1, r_tag};
        for (int t = 1; t < MAX_WAYS; t++) begin
            if (t <= 32'(w_lim)) begin
                w_new[t*ENT_W +: ENT_W] = w_row[(t-1)*ENT_W +: ENT_W];
            end
        end
    end

    // Saturating sums for the running totals.
    always_comb begin
        w_hit_sum   = {1'b0, r_tot_hits} + (CNT_W+1)'(w_hits);
        w_miss_sum  = {1'b0, r_tot_misses} + (CNT_W+1)'(!w_found);
        w_evict_sum = {1'b0, r_tot_evicts} + (CNT_W+1)'(w_evict);
    end

    // Set written flags and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_init   <= '0;
            r_tot_hits   <= '0;
            r_tot_misses <= '0;
            r_tot_evicts <= '0;
        end else if (i_cmd.upd) begin
            r_row_init[r_set] <= 1'b1;
            r_tot_hits   <= w_hit_sum[CNT_W] ? CNT_MAX : w_hit_sum[CNT_W-1:0];
            r_tot_misses <= w_miss_sum[CNT_W] ? CNT_MAX : w_miss_sum[CNT_W-1:0];
            r_tot_evicts <= w_evict_sum[CNT_W] ? CNT_MAX : w_evict_sum[CNT_W-1:0];
        end
    end

    // Per-access counts of the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_acc_hits  <= w_hits;
            r_acc_miss  <= !w_found;
            r_acc_evict <= w_evict;
        end
    end

    assign o_result = {(OUT_W - RES_W)'(0), r_tot_evicts, r_tot_misses, r_tot_hits,
                       r_acc_evict, r_acc_miss, r_acc_hits};

endmodule

FILE: rtl/salc_ctrl.sv
// ---------------------------------------------------------------------------
// salc_ctrl
// Controller: sequences each request through set read and write-back, and
// owns the handshakes of both stream sides.
// ---------------------------------------------------------------------------
module salc_ctrl
    import salc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    // The result register is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || i_m_tready;

    // Commands and next state.
    always_comb begin
        o_cmd.rd    = 1'b0;
        o_cmd.upd   = 1'b0;
        n_state     = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on write-back, cleared when taken.
    always_comb begin
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: rtl/salc_chk.sv
// ---------------------------------------------------------------------------
// salc_chk
// Port-level checks of the cache counter, bound to the top level.
// ---------------------------------------------------------------------------
module salc_chk
    import salc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_W-1:0]      o_m_tdata
);

    // A stalled result stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // An accepted access occupies the lookup for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("access accepted during lookup");

    // An eviction is only reported with a miss.
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[3] && !o_m_tdata[2]))
        else $error("eviction without miss");

    // Running totals never decrease outside reset.
    a_totals_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (o_m_tdata[35:4] >= $past(o_m_tdata[35:4]))
            && (o_m_tdata[67:36] >= $past(o_m_tdata[67:36]))
            && (o_m_tdata[99:68] >= $past(o_m_tdata[99:68])))
        else $error("running total decreased");

endmodule

bind set_assoc_lru_cache_counter salc_chk u_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench of the set-associative LRU cache counter.
// ---------------------------------------------------------------------------
// Memory accesses go in on the slave stream. A cache model inside this bench
// keeps its own tags, LRU order and totals, and predicts the counts of each
// access. Each result request is compared field by field with the oldest
// prediction. Directed tests cover the reset geometry, the clamped and
// oversized address splits, the spare access kind and LRU ordering. Random
// phases then run over several geometries with varied handshake idling. One
// phase holds the receiver off long enough to stall the access stream.
// ---------------------------------------------------------------------------
module tb;
    import salc_pkg::*;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 2000;

    // Access kinds besides modify, which comes from the package.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]       hits;
        logic             miss;
        logic             evict;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } t_access_counts;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [ADDR_W-1:0]     i_s_tdata;
    logic [FUNC_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Cache model state.
    bit [TAG_W-1:0]   cached_tag [NUM_SETS][MAX_WAYS];
    bit               cached_valid [NUM_SETS][MAX_WAYS];
    logic [CNT_W-1:0] hit_count   = '0;
    logic [CNT_W-1:0] miss_count  = '0;
    logic [CNT_W-1:0] evict_count = '0;
    logic [SB_W-1:0]   cfg_set_bits   = '0;
    logic [WAYS_W-1:0] cfg_ways       = 4'd1;
    logic [BB_W-1:0]   cfg_block_bits = '0;

    t_access_counts expected_counts_q[$];

    // Stimulus shaping.
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    bit               stall_kick    = 1'b0;
    int unsigned      hold_left     = 0;
    logic [ADDR_W-1:0] tag_base     = '0;
    int unsigned      tag_span      = 1;
    int unsigned      set_span      = 1;
    int unsigned      mismatches    = 0;
    int unsigned      idle_cycles   = 0;

    set_assoc_lru_cache_counter #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Effective geometry after clamping of out-of-range register values.
    function automatic int unsigned eff_set_bits();
        return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0) return 1;
        return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] base,
                                                 int unsigned step);
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + step;
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    // Look the access up in the model cache, update LRU order and totals,
    // and queue the counts that the block must report.
    task automatic predict_counts(input logic [FUNC_W-1:0] func,
                                  input logic [ADDR_W-1:0] addr);
        int unsigned sb, nw, bb, split, set_idx, way;
        logic [TAG_W-1:0] tag;
        bit found, full;
        t_access_counts counts;
        sb = eff_set_bits();
        nw = eff_ways();
        bb = cfg_block_bits;
        split = sb + bb;
        set_idx = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
        tag = (split >= 64) ? '0 : (addr >> split);
        found = 1'b0;
        full = 1'b1;
        way = nw - 1;
        for (int i = 0; i < nw; i++) begin
            if (!found && cached_valid[set_idx][i] && cached_tag[set_idx][i] == tag) begin
                found = 1'b1;
                way = i;
            end
            if (!cached_valid[set_idx][i]) full = 1'b0;
        end
        counts.hits = found ? 2'd1 : 2'd0;
        counts.miss = !found;
        counts.evict = !found && full;
        // Shift the more recent lines down one place, then insert at the head.
        for (int t = way; t > 0; t--) begin
            cached_tag[set_idx][t] = cached_tag[set_idx][t-1];
            cached_valid[set_idx][t] = cached_valid[set_idx][t-1];
        end
        cached_tag[set_idx][0] = tag;
        cached_valid[set_idx][0] = 1'b1;
        if (func == FUNC_MODIFY) counts.hits = counts.hits + 2'd1;
        hit_count = sat_inc(hit_count, counts.hits);
        miss_count = sat_inc(miss_count, counts.miss);
        evict_count = sat_inc(evict_count, counts.evict);
        counts.hit_total = hit_count;
        counts.miss_total = miss_count;
        counts.evict_total = evict_count;
        expected_counts_q.push_back(counts);
    endtask

    // Offer one access request; returns at the falling edge after acceptance
    // with tvalid still high so that back-to-back requests stay continuous.
    task automatic send_access(input logic [FUNC_W-1:0] func,
                               input logic [ADDR_W-1:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= addr;
        i_s_tuser <= func;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_counts(func, addr);
        @(negedge i_clk);
    endtask

    // Write one register and mirror it in the model.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SET_BITS: begin
                cfg_set_bits = value[SB_W-1:0];
            end
            CFG_WAYS: begin
                cfg_ways = value[WAYS_W-1:0];
            end
            CFG_BLOCK_BITS: begin
                cfg_block_bits = value[BB_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (expected_counts_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sb_val,
                                input logic [CFG_DATA_W-1:0] ways_val,
                                input logic [CFG_DATA_W-1:0] bb_val);
        wait_drain();
        write_register(CFG_SET_BITS, sb_val);
        write_register(CFG_WAYS, ways_val);
        write_register(CFG_BLOCK_BITS, bb_val);
    endtask

    // Mostly addresses from a small pool of tags and sets so that lines are
    // reused and evicted; the rest is fully random noise.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] noise, tag, set_part, offset_mask;
        int unsigned sb, bb;
        noise = {$urandom, $urandom};
        if ($urandom_range(99) < 15) return noise;
        sb = eff_set_bits();
        bb = cfg_block_bits;
        offset_mask = (64'd1 << bb) - 64'd1;
        tag = tag_base + $urandom_range(tag_span - 1);
        set_part = $urandom_range(set_span - 1);
        return (tag << (sb + bb)) | (set_part << bb) | (noise & offset_mask);
    endfunction

    // One random phase on a given geometry; stall_at picks the request at
    // which the receiver starts a long hold-off, or none when negative.
    task automatic run_mix_phase(input logic [CFG_DATA_W-1:0] sb_val,
                                 input logic [CFG_DATA_W-1:0] ways_val,
                                 input logic [CFG_DATA_W-1:0] bb_val,
                                 input int n_items, input int stall_at);
        set_geometry(sb_val, ways_val, bb_val);
        tag_base = {$urandom, $urandom};
        tag_span = eff_ways() + $urandom_range(1, 3);
        set_span = $urandom_range(1, 8);
        if (set_span > (1 << eff_set_bits())) set_span = 1 << eff_set_bits();
        for (int n = 0; n < n_items; n++) begin
            if (n == stall_at) stall_kick = 1'b1;
            send_access(2'($urandom_range(3)), pick_address());
        end
    endtask

    // Reset geometry: one set of one way, whole address is the tag.
    task automatic test_reset_defaults();
        send_access(FUNC_LOAD, '0);
        send_access(FUNC_STORE, '0);
        send_access(FUNC_MODIFY, '1);
        send_access(FUNC_SPARE, '1);
        send_access(FUNC_MODIFY, '1);
    endtask

    // Clamped set count and way count, and a split beyond the address so
    // that every tag is zero and the set comes from the top address bit.
    task automatic test_split_extremes();
        set_geometry(6'h3F, 6'h3F, 6'h3F);
        write_register(CFG_UNUSED, 6'h2A);
        send_access(FUNC_LOAD, '0);
        send_access(FUNC_LOAD, 64'h8000_0000_0000_0000);
        send_access(FUNC_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_access(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        // Zero ways count as one; block offset 58 puts the set in address bit 58.
        set_geometry(6'd1, 6'd0, 6'd58);
        send_access(FUNC_LOAD, 64'h0400_0000_0000_0000);
        send_access(FUNC_LOAD, 64'h0800_0000_0000_0000);
        send_access(FUNC_LOAD, 64'h0C00_0000_0000_0000);
    endtask

    // LRU order in one set of four ways, then a narrower way count that
    // leaves older lines unsearched.
    task automatic test_lru_order();
        set_geometry(6'd0, 6'd4, 6'd0);
        send_access(FUNC_LOAD, 64'h10);
        send_access(FUNC_LOAD, 64'h20);
        send_access(FUNC_LOAD, 64'h30);
        send_access(FUNC_LOAD, 64'h40);
        send_access(FUNC_STORE, 64'h10);
        send_access(FUNC_LOAD, 64'h50);
        send_access(FUNC_MODIFY, 64'h20);
        set_geometry(6'd0, 6'd2, 6'd0);
        send_access(FUNC_LOAD, 64'h30);
        send_access(FUNC_LOAD, 64'h20);
    endtask

    task automatic test_random_sender_light();
        run_mix_phase(6'd2, 6'd4, 6'd4, 130, -1);
        run_mix_phase(6'd6, 6'd8, 6'd6, 130, -1);
        run_mix_phase(6'd0, 6'd1, 6'd0, 130, -1);
    endtask

    task automatic test_random_receiver_light();
        run_mix_phase(6'd3, 6'd2, 6'd58, 130, -1);
        run_mix_phase(6'd1, 6'd15, 6'd2, 130, -1);
        run_mix_phase(6'd7, 6'd0, 6'd5, 130, -1);
    endtask

    task automatic test_random_no_idle();
        run_mix_phase(6'd4, 6'd3, 6'd12, 130, 20);
        run_mix_phase(6'd6, 6'd8, 6'd58, 130, -1);
        run_mix_phase(6'd5, 6'd6, 6'd31, 130, -1);
    endtask

    // Result receiver: random stalls, or a long hold-off when kicked.
    always @(negedge i_clk) begin
        if (stall_kick) begin
            stall_kick = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result request with the oldest prediction.
    always @(posedge i_clk) begin
        t_access_counts want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_counts_q.size() == 0) begin
                $display("%0t: unexpected result request: expected none, actual %h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                want = expected_counts_q.pop_front();
                check_field("access_hits", CNT_W'(want.hits), CNT_W'(o_m_tdata[1:0]));
                check_field("access_miss", CNT_W'(want.miss), CNT_W'(o_m_tdata[2]));
                check_field("access_eviction", CNT_W'(want.evict),
                            CNT_W'(o_m_tdata[3]));
                check_field("total_hits", want.hit_total, o_m_tdata[35:4]);
                check_field("total_misses", want.miss_total, o_m_tdata[67:36]);
                check_field("total_evictions", want.evict_total, o_m_tdata[99:68]);
            end
        end
    end

    // Watchdog on cycles in which no request of any kind is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("set_assoc_lru_cache_counter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender lightly idle, receiver often stalled.
        send_idle_pct = 7;
        recv_idle_pct = 48;
        test_reset_defaults();
        test_split_extremes();
        test_lru_order();
        test_random_sender_light();

        // Sender often idle, receiver lightly stalled.
        send_idle_pct = 48;
        recv_idle_pct = 7;
        test_random_receiver_light();

        // Full rate on both sides, with one long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_no_idle();

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("set_assoc_lru_cache_counter regression: pass");
        end else begin
            $display("set_assoc_lru_cache_counter regression: fail");
        end
        $finish;
    end

endmodule
